// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; clock and reset are passed in by the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ECR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted
`define ECR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hw/rtl/ecr_pkg.sv =====
// Types, codes and constants of the ellipse fit residual checker.
// No dependencies; used by every other file of the block but assert_macros.svh.
`timescale 1ns / 1ps

package ecr_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_CENTER_X  = 3'd0;
  localparam logic [2:0] REG_CENTER_Y  = 3'd1;
  localparam logic [2:0] REG_WIDTH     = 3'd2;
  localparam logic [2:0] REG_HEIGHT    = 3'd3;
  localparam logic [2:0] REG_ANGLE     = 3'd4;
  localparam logic [2:0] REG_MAX_ERROR = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Angle handling, 1/256 degree units
  localparam logic [16:0] FULL_TURN    = 17'd92160;
  localparam logic [16:0] QUARTER_TURN = 17'd23040;
  localparam logic [16:0] HALF_TURN    = 17'd46080;
  localparam logic [16:0] THREE_QUART  = 17'd69120;

  localparam int CORDIC_STEPS = 16;
  localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  localparam logic signed [17:0] TRIG_ONE = 18'sd65536;
  localparam logic [31:0] UNIT_Q16   = 32'd65536;
  localparam logic [39:0] SUM_MAX    = 40'hFF_FFFF_FFFF;
  localparam logic [30:0] RATIO_SAT  = 31'h7FFF_FFFF;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DIVP,
    S_DIVQ,
    S_SQR,
    S_EMUL,
    S_ACC,
    S_CMP
  } ecr_state_t;

  // Operation of the shared divide / square root unit
  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } ecr_op_t;

  typedef struct packed {
    logic    start;
    ecr_op_t op;
  } ecr_unit_cmd_t;

  // Arctangent of 2^-i in 1/65536 degree
  function automatic logic [21:0] atan_q(input logic [3:0] idx);
    logic [21:0] v;
    case (idx)
      4'd0:    v = 22'd2949120;
      4'd1:    v = 22'd1740967;
      4'd2:    v = 22'd919879;
      4'd3:    v = 22'd466945;
      4'd4:    v = 22'd234379;
      4'd5:    v = 22'd117304;
      4'd6:    v = 22'd58666;
      4'd7:    v = 22'd29335;
      4'd8:    v = 22'd14668;
      4'd9:    v = 22'd7334;
      4'd10:   v = 22'd3667;
      4'd11:   v = 22'd1833;
      4'd12:   v = 22'd917;
      4'd13:   v = 22'd458;
      4'd14:   v = 22'd229;
      default: v = 22'd115;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/ecr_if.sv =====
// Valid/ready channel interfaces: contour points in, fit results out, config writes.
// Depends on ecr_pkg for configuration port widths.
`timescale 1ns / 1ps

interface ecr_in_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  last_point;
  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface ecr_out_if;
  logic        valid;
  logic        ready;
  logic        fit_ok;
  logic [39:0] total_error;
  logic [12:0] point_count;
  modport source (output valid, fit_ok, total_error, point_count, input ready);
  modport sink   (input valid, fit_ok, total_error, point_count, output ready);
endinterface

interface ecr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ecr_pkg::CFG_IDX_W-1:0]  index;
  logic [ecr_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ecr_cordic.sv =====
// Iterative CORDIC that turns the ellipse angle into Q16 sine and cosine.
// Depends on ecr_pkg (arctangent table, gain, angle constants).
`timescale 1ns / 1ps

module ecr_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [16:0]        angle,
  output logic               busy,
  output logic signed [17:0] sine,
  output logic signed [17:0] cosine
);
  import ecr_pkg::*;

  logic signed [32:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [24:0] z_r, z_nxt;
  logic [1:0]         quad_r, quad_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic signed [17:0] sin_r, sin_nxt, cos_r, cos_nxt;

  logic [16:0]        a_red, a_rem;
  logic [1:0]         a_quad;
  logic signed [32:0] xs, ys;
  logic signed [24:0] atan_s;
  logic signed [17:0] c_rnd, s_rnd;

  // Round a Q30 value half away from zero to Q16, clamped to one
  function automatic logic signed [17:0] rnd_q16(input logic signed [32:0] v);
    logic [32:0] mag;
    logic [32:0] rm;
    logic [17:0] cl;
    mag = v[32] ? 33'(-v) : 33'(v);
    rm  = (mag + 33'd8192) >> 14;
    cl  = (rm > 33'd65536) ? 18'd65536 : rm[17:0];
    return v[32] ? -signed'(cl) : signed'(cl);
  endfunction

  // Angle reduction to quadrant plus remainder
  always_comb begin
    a_red = (angle >= FULL_TURN) ? angle - FULL_TURN : angle;
    if (a_red >= THREE_QUART) begin
      a_quad = 2'd3;
      a_rem  = a_red - THREE_QUART;
    end else if (a_red >= HALF_TURN) begin
      a_quad = 2'd2;
      a_rem  = a_red - HALF_TURN;
    end else if (a_red >= QUARTER_TURN) begin
      a_quad = 2'd1;
      a_rem  = a_red - QUARTER_TURN;
    end else begin
      a_quad = 2'd0;
      a_rem  = a_red;
    end
  end

  assign xs     = x_r >>> cnt_r[3:0];
  assign ys     = y_r >>> cnt_r[3:0];
  assign atan_s = signed'(25'(atan_q(cnt_r[3:0])));
  assign c_rnd  = rnd_q16(x_r);
  assign s_rnd  = rnd_q16(y_r);

  // Rotation steps and final quadrant fix-up
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    quad_nxt = quad_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    sin_nxt  = sin_r;
    cos_nxt  = cos_r;
    if (start) begin
      x_nxt    = CORDIC_GAIN_Q30;
      y_nxt    = '0;
      z_nxt    = signed'({a_rem, 8'd0});
      quad_nxt = a_quad;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 5'(CORDIC_STEPS)) begin
        busy_nxt = 1'b0;
        case (quad_r)
          2'd0: begin
            cos_nxt = c_rnd;
            sin_nxt = s_rnd;
          end
          2'd1: begin
            cos_nxt = -s_rnd;
            sin_nxt = c_rnd;
          end
          2'd2: begin
            cos_nxt = -c_rnd;
            sin_nxt = -s_rnd;
          end
          default: begin
            cos_nxt = s_rnd;
            sin_nxt = -c_rnd;
          end
        endcase
      end else begin
        if (!z_r[24]) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - atan_s;
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + atan_s;
        end
        cnt_nxt = cnt_r + 5'd1;
      end
    end
  end

  // Reset loads a run on angle zero, so the trig values come out of the same rotation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      sin_r  <= '0;
      cos_r  <= TRIG_ONE;
      x_r    <= CORDIC_GAIN_Q30;
      y_r    <= '0;
      z_r    <= '0;
      quad_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      sin_r  <= sin_nxt;
      cos_r  <= cos_nxt;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      quad_r <= quad_nxt;
    end
  end

  assign busy   = busy_r;
  assign sine   = sin_r;
  assign cosine = cos_r;

endmodule

// ===== hw/rtl/ecr_divsqrt.sv =====
// Shared radix-2 unit: saturating divide (31 quotient bits) or 64-bit integer square root.
// Depends on ecr_pkg (command struct, operation codes).
`timescale 1ns / 1ps

module ecr_divsqrt #(
  parameter int NUMW = 41
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ecr_pkg::ecr_unit_cmd_t cmd,
  input  logic [NUMW-1:0]       num,
  input  logic [19:0]           den,
  input  logic [63:0]           rad,
  output logic                  done,
  output logic [31:0]           result
);
  import ecr_pkg::*;

  localparam int HIW = NUMW - 31;

  logic [35:0] rem_r, rem_nxt;
  logic [63:0] sh_r, sh_nxt;
  logic [31:0] root_r, root_nxt;
  logic [19:0] den_r, den_nxt;
  ecr_op_t     op_r, op_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  logic [HIW-1:0] num_hi;
  logic [37:0]    opa, opb, diff;
  logic           ge;

  assign num_hi = num[NUMW-1:31];

  // One shared compare-subtract serves both operations
  always_comb begin
    if (op_r == OP_DIV) begin
      opa = 38'({rem_r[19:0], sh_r[63]});
      opb = 38'(den_r);
    end else begin
      opa = {rem_r, sh_r[63:62]};
      opb = 38'({root_r, 2'b01});
    end
    ge   = opa >= opb;
    diff = opa - opb;
  end

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    root_nxt = root_r;
    den_nxt  = den_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      op_nxt   = cmd.op;
      den_nxt  = den;
      root_nxt = '0;
      busy_nxt = 1'b1;
      if (cmd.op == OP_DIV) begin
        rem_nxt = 36'(num_hi);
        sh_nxt  = {num[30:0], 33'd0};
        cnt_nxt = 6'd31;
        // quotient would not fit 31 bits: saturate at once
        if (21'(num_hi) >= 21'(den)) begin
          root_nxt = 32'(RATIO_SAT);
          cnt_nxt  = 6'd0;
        end
      end else begin
        rem_nxt = '0;
        sh_nxt  = rad;
        cnt_nxt = 6'd32;
      end
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = ge ? diff[35:0] : opa[35:0];
        root_nxt = {root_r[30:0], ge};
        sh_nxt   = (op_r == OP_DIV) ? {sh_r[62:0], 1'b0} : {sh_r[61:0], 2'b00};
        cnt_nxt  = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    sh_r   <= sh_nxt;
    root_r <= root_nxt;
    den_r  <= den_nxt;
    op_r   <= op_nxt;
  end

  assign done   = done_r;
  assign result = root_r;

endmodule

// ===== hw/rtl/ellipse_fit_residual_check.sv =====
// Top level of the ellipse fit residual checker: config registers, sequencer, multiplier.
// Depends on ecr_pkg, ecr_if, ecr_cordic and ecr_divsqrt.
//
//   channel  dir  payload                                   accepted when
//   in_ch    in   point_x, point_y, last_point              valid & ready
//   out_ch   out  fit_ok, total_error, point_count          valid & ready
//   cfg_ch   in   index (3 b), data (32 b)                  valid & ready
//
// A scored point goes through accept, 5 rotation multiply steps, two divides (cut short
// when a ratio saturates), the squares and square root, the error square and accumulate.
// A zero axis skips the divides and squares; past MAX_POINTS a point goes straight to
// accumulate uncounted. A last point adds the threshold compare, held while the previous
// result still waits on out_ch. in_ch and cfg_ch are ready only while the sequencer is
// idle and the CORDIC is not running; it runs after reset and an angle write. Sync reset.
`timescale 1ns / 1ps

module ellipse_fit_residual_check #(
  parameter int MAX_POINTS = 4096,
  parameter int COORD_BITS = 12
) (
  input logic       clk,
  input logic       rst_n,
  ecr_in_if.sink    in_ch,
  ecr_out_if.source out_ch,
  ecr_cfg_if.sink   cfg_ch
);
  import ecr_pkg::*;

  localparam int DXW  = (((COORD_BITS + 8) > 20) ? (COORD_BITS + 8) : 20) + 2;
  localparam int UW   = DXW + 18;
  localparam int NUMW = UW + 1;
  localparam int CNTW = $clog2(MAX_POINTS + 1);

  // Configuration registers
  logic signed [20:0] cx_r, cy_r;
  logic [19:0]        w_r, h_r;
  logic [31:0]        mfe_r;

  // Sequencer and datapath registers
  ecr_state_t         state_r, state_nxt;
  logic [2:0]         step_r, step_nxt;
  logic               last_r, last_nxt, skip_r, skip_nxt;
  logic signed [DXW-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [UW-1:0]  u_r, u_nxt, v_r, v_nxt;
  logic signed [65:0] acc_r, acc_nxt, prod_r;
  logic [30:0]        p_r, p_nxt, q_r, q_nxt;
  logic [31:0]        e_r, e_nxt;
  logic [47:0]        err_r, err_nxt;
  logic [39:0]        sum_r, sum_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;

  // Result register
  logic               ov_r, ov_nxt, ok_r, ok_nxt;
  logic [39:0]        otot_r, otot_nxt;
  logic [12:0]        ocnt_r, ocnt_nxt;

  logic signed [32:0] mul_a, mul_b;
  logic signed [17:0] sine, cosine;
  logic               cordic_busy, cordic_start;
  logic               in_acc, cfg_acc, zero_axis;
  ecr_unit_cmd_t      ucmd;
  logic [NUMW-1:0]    unum;
  logic [19:0]        uden;
  logic [63:0]        urad;
  logic               udone;
  logic [31:0]        ures;
  logic [UW-1:0]      abs_sel;
  logic signed [UW-1:0] u_sel;
  logic [65:0]        sum_sq;
  logic [63:0]        err_rnd;
  logic [48:0]        sum_add;

  assign in_ch.ready  = (state_r == S_IDLE) && !cordic_busy;
  assign cfg_ch.ready = (state_r == S_IDLE) && !cordic_busy;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign cordic_start = cfg_acc && (cfg_ch.index == REG_ANGLE);
  assign zero_axis    = (w_r == 20'd0) || (h_r == 20'd0);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      w_r   <= '0;
      h_r   <= '0;
      mfe_r <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_ch.index)
        REG_CENTER_X:  cx_r  <= signed'(cfg_ch.data[20:0]);
        REG_CENTER_Y:  cy_r  <= signed'(cfg_ch.data[20:0]);
        REG_WIDTH:     w_r   <= cfg_ch.data[19:0];
        REG_HEIGHT:    h_r   <= cfg_ch.data[19:0];
        REG_MAX_ERROR: mfe_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  ecr_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cordic_start),
    .angle  (cfg_ch.data[16:0]),
    .busy   (cordic_busy),
    .sine   (sine),
    .cosine (cosine)
  );

  // Divide operand: 2|t| + axis/2 over the axis, for u then v
  assign u_sel   = (state_r == S_DIVQ) ? v_r : u_r;
  assign abs_sel = u_sel[UW-1] ? UW'(-u_sel) : UW'(u_sel);
  assign uden    = (state_r == S_DIVQ) ? h_r : w_r;
  assign unum    = {abs_sel, 1'b0} + NUMW'(uden >> 1);
  assign sum_sq  = 66'(acc_r + prod_r);
  assign urad    = sum_sq[63:0];

  ecr_divsqrt #(.NUMW(NUMW)) u_divsqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (ucmd),
    .num    (unum),
    .den    (uden),
    .rad    (urad),
    .done   (udone),
    .result (ures)
  );

  // The one shared multiplier, registered
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign err_rnd = prod_r[63:0] + 64'd32768;
  assign sum_add = 49'(sum_r) + 49'(err_r);

  // Sequencer: next state, operands and datapath updates
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    last_nxt  = last_r;
    skip_nxt  = skip_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    acc_nxt   = acc_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    e_nxt     = e_r;
    err_nxt   = err_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    ok_nxt    = ok_r;
    otot_nxt  = otot_r;
    ocnt_nxt  = ocnt_r;
    ov_nxt    = ov_r && !out_ch.ready;
    mul_a     = 33'(dx_r);
    mul_b     = 33'(cosine);
    ucmd.start = 1'b0;
    ucmd.op    = OP_DIV;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          dx_nxt   = DXW'(signed'({1'b0, in_ch.point_x, 8'd0})) - DXW'(cx_r);
          dy_nxt   = DXW'(signed'({1'b0, in_ch.point_y, 8'd0})) - DXW'(cy_r);
          last_nxt = in_ch.last_point;
          skip_nxt = cnt_r >= CNTW'(MAX_POINTS);
          step_nxt = '0;
          state_nxt = (cnt_r >= CNTW'(MAX_POINTS)) ? S_ACC : S_MUL;
        end
      end
      // Rotation: u = dx*cos + dy*sin, v = dy*cos - dx*sin
      S_MUL: begin
        step_nxt = step_r + 3'd1;
        case (step_r)
          3'd0: begin
            mul_a = 33'(dx_r);
            mul_b = 33'(cosine);
          end
          3'd1: begin
            acc_nxt = prod_r;
            mul_a   = 33'(dy_r);
            mul_b   = 33'(sine);
          end
          3'd2: begin
            u_nxt = UW'(acc_r + prod_r);
            mul_a = 33'(dy_r);
            mul_b = 33'(cosine);
          end
          3'd3: begin
            acc_nxt = prod_r;
            mul_a   = 33'(dx_r);
            mul_b   = 33'(sine);
          end
          default: begin
            v_nxt    = UW'(acc_r - prod_r);
            step_nxt = '0;
            err_nxt  = '0;
            state_nxt = zero_axis ? S_ACC : S_DIVP;
          end
        endcase
      end
      S_DIVP: begin
        if (step_r == 3'd0) begin
          ucmd.start = 1'b1;
          step_nxt   = 3'd1;
        end else if (udone) begin
          p_nxt     = ures[30:0];
          step_nxt  = '0;
          state_nxt = S_DIVQ;
        end
      end
      S_DIVQ: begin
        if (step_r == 3'd0) begin
          ucmd.start = 1'b1;
          step_nxt   = 3'd1;
        end else if (udone) begin
          q_nxt     = ures[30:0];
          step_nxt  = '0;
          state_nxt = S_SQR;
        end
      end
      // r = isqrt(p*p + q*q), then e = |r - 1|
      S_SQR: begin
        mul_a = signed'({2'b00, p_r});
        mul_b = signed'({2'b00, p_r});
        case (step_r)
          3'd0: step_nxt = 3'd1;
          3'd1: begin
            acc_nxt  = prod_r;
            mul_a    = signed'({2'b00, q_r});
            mul_b    = signed'({2'b00, q_r});
            step_nxt = 3'd2;
          end
          3'd2: begin
            ucmd.start = 1'b1;
            ucmd.op    = OP_SQRT;
            step_nxt   = 3'd3;
          end
          default: begin
            if (udone) begin
              e_nxt     = (ures >= UNIT_Q16) ? ures - UNIT_Q16 : UNIT_Q16 - ures;
              step_nxt  = '0;
              state_nxt = S_EMUL;
            end
          end
        endcase
      end
      S_EMUL: begin
        mul_a = signed'({1'b0, e_r});
        mul_b = signed'({1'b0, e_r});
        if (step_r == 3'd0) begin
          step_nxt = 3'd1;
        end else begin
          err_nxt   = err_rnd[63:16];
          step_nxt  = '0;
          state_nxt = S_ACC;
        end
      end
      // Saturating sum and point count
      S_ACC: begin
        if (!skip_r) begin
          sum_nxt = (sum_add > 49'(SUM_MAX)) ? SUM_MAX : sum_add[39:0];
          cnt_nxt = cnt_r + CNTW'(1);
        end
        step_nxt  = '0;
        state_nxt = last_r ? S_CMP : S_IDLE;
      end
      // Threshold compare and result hand-off
      S_CMP: begin
        mul_a = signed'({1'b0, mfe_r});
        mul_b = signed'(33'(cnt_r));
        if (step_r == 3'd0) begin
          step_nxt = 3'd1;
        end else if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          ok_nxt    = !zero_axis && (64'(sum_r) < prod_r[63:0]);
          otot_nxt  = sum_r;
          ocnt_nxt  = 13'(cnt_r);
          sum_nxt   = '0;
          cnt_nxt   = '0;
          step_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      sum_r   <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    skip_r <= skip_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    acc_r  <= acc_nxt;
    p_r    <= p_nxt;
    q_r    <= q_nxt;
    e_r    <= e_nxt;
    err_r  <= err_nxt;
    ok_r   <= ok_nxt;
    otot_r <= otot_nxt;
    ocnt_r <= ocnt_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.fit_ok      = ok_r;
  assign out_ch.total_error = otot_r;
  assign out_ch.point_count = ocnt_r;

endmodule

// ===== hw/rtl/ecr_checker.sv =====
// Port-level checks of the ellipse fit residual checker, bound to the top level.
// Depends on ecr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ecr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_fit_ok,
  input logic [39:0] out_total_error,
  input logic [12:0] out_point_count,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [ecr_pkg::CFG_IDX_W-1:0] cfg_index
);
  import ecr_pkg::*;

  // An accepted item leaves in_ch not ready in the next cycle
  `ECR_ASSERT_NEXT(a_busy_after_item, clk, rst_n, in_valid && in_ready, !in_ready)

  // An angle write starts the CORDIC, which blocks further writes
  `ECR_ASSERT_NEXT(a_angle_blocks_cfg, clk, rst_n, cfg_valid && cfg_ready && (cfg_index == REG_ANGLE), !cfg_ready)

  // A result only appears out of a busy cycle
  `ECR_ASSERT_SAME(a_result_from_busy, clk, rst_n, $rose(out_valid), !$past(in_ready))

  // A stalled result holds
  `ECR_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_fit_ok) && $stable(out_total_error) && $stable(out_point_count))

endmodule

bind ellipse_fit_residual_check ecr_checker u_ecr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_fit_ok      (out_ch.fit_ok),
  .out_total_error (out_ch.total_error),
  .out_point_count (out_ch.point_count),
  .cfg_valid       (cfg_ch.valid),
  .cfg_ready       (cfg_ch.ready),
  .cfg_index       (cfg_ch.index)
);

// ===== tb/tb_ellipse_fit_residual_check.sv =====
// Self-checking testbench for the ellipse fit residual checker: directed table, then random contours.
// Depends on ecr_pkg, ecr_if and the ellipse_fit_residual_check RTL.
`timescale 1ns / 1ps

module tb_ellipse_fit_residual_check;
  import ecr_pkg::*;

  localparam int MAX_PTS = 4096;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic        fit_ok;
    logic [39:0] total_error;
    logic [12:0] point_count;
  } fit_result_t;

  // Directed row: a register write or a point; expected result given when known
  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [31:0] reg_data;
    logic [11:0] px;
    logic [11:0] py;
    bit          last;
    bit          has_exp;
    fit_result_t exp_res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  ecr_in_if  #(.COORD_BITS(12)) in_ch ();
  ecr_out_if out_ch ();
  ecr_cfg_if cfg_ch ();

  ellipse_fit_residual_check #(.MAX_POINTS(MAX_PTS), .COORD_BITS(12)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // Shadow of the ellipse registers and the accumulator
  longint      m_cx, m_cy;
  int unsigned m_w, m_h, m_angle, m_max_err;
  longint      m_sin, m_cos;
  logic [39:0] m_sum;
  int unsigned m_count;

  fit_result_t fit_results_due[$];
  int          n_fail;
  int          idle_cycles;
  int          send_idle_pct, recv_idle_pct;

  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint round_to_q16(longint v);
    longint r;
    r = (v >= 0) ? ((v + 8192) >>> 14) : -(((-v) + 8192) >>> 14);
    if (r > 65536) r = 65536;
    if (r < -65536) r = -65536;
    return r;
  endfunction

  // CORDIC sine/cosine of the angle register, quadrant applied exactly
  task automatic recompute_trig();
    int unsigned a, quad;
    longint z, x, y, xs, ys, c, s;
    a = m_angle % 92160;
    quad = a / 23040;
    z = longint'(a - quad * 23040) * 256;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_q(i[3:0]));
      end else begin
        x += ys; y -= xs; z += longint'(atan_q(i[3:0]));
      end
    end
    c = round_to_q16(x);
    s = round_to_q16(y);
    case (quad)
      0: begin m_cos = c;  m_sin = s;  end
      1: begin m_cos = -s; m_sin = c;  end
      2: begin m_cos = -c; m_sin = -s; end
      default: begin m_cos = s; m_sin = -c; end
    endcase
  endtask

  task automatic shadow_write(logic [2:0] idx, logic [31:0] d);
    case (idx)
      REG_CENTER_X:  m_cx = longint'($signed(d[20:0]));
      REG_CENTER_Y:  m_cy = longint'($signed(d[20:0]));
      REG_WIDTH:     m_w = d[19:0];
      REG_HEIGHT:    m_h = d[19:0];
      REG_ANGLE: begin
        m_angle = d[16:0];
        recompute_trig();
      end
      REG_MAX_ERROR: m_max_err = d;
      default: ;
    endcase
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned axis_ratio(longint t, int unsigned ax);
    longint unsigned m, p;
    m = (t < 0) ? -t : t;
    p = (2 * m + ax / 2) / ax;
    return (p > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : p;
  endfunction

  function automatic longint unsigned residual_sq(logic [11:0] px, logic [11:0] py);
    longint dx, dy, u, v;
    longint unsigned p, q, r, e;
    if (m_w == 0 || m_h == 0) return 0;
    dx = longint'(px) * 256 - m_cx;
    dy = longint'(py) * 256 - m_cy;
    u = dx * m_cos + dy * m_sin;
    v = dy * m_cos - dx * m_sin;
    p = axis_ratio(u, m_w);
    q = axis_ratio(v, m_h);
    r = int_sqrt(p * p + q * q);
    e = (r >= 65536) ? r - 65536 : 65536 - r;
    return (e * e + 32768) >> 16;
  endfunction

  // Accumulate one point; returns 1 with the contour verdict on a last point
  function automatic bit score_point(logic [11:0] px, logic [11:0] py, bit last,
                                     output fit_result_t res);
    longint unsigned s;
    res = '0;
    if (m_count < MAX_PTS) begin
      s = longint'(m_sum) + residual_sq(px, py);
      m_sum = (s > 64'hFF_FFFF_FFFF) ? SUM_MAX : s[39:0];
      m_count++;
    end
    if (!last) return 0;
    res.fit_ok = (m_w != 0 && m_h != 0 &&
                  longint'(m_sum) < longint'(m_max_err) * m_count);
    res.total_error = m_sum;
    res.point_count = m_count[12:0];
    m_sum = '0;
    m_count = 0;
    return 1;
  endfunction

  // Append one result to the list of those still to come
  task automatic queue_result(fit_result_t res);
    fit_results_due = {fit_results_due, res};
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result checker and receiver stalls
  always @(posedge clk) begin
    fit_result_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.fit_ok, out_ch.total_error, out_ch.point_count};
        if (fit_results_due.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          n_fail++;
        end else begin
          want = fit_results_due.pop_front();
          if (got.fit_ok !== want.fit_ok) begin
            $display("%0t: fit_ok expected %0d actual %0d", $time, want.fit_ok, got.fit_ok);
            n_fail++;
          end
          if (got.total_error !== want.total_error) begin
            $display("%0t: total_error expected %0d actual %0d", $time,
                     want.total_error, got.total_error);
            n_fail++;
          end
          if (got.point_count !== want.point_count) begin
            $display("%0t: point_count expected %0d actual %0d", $time,
                     want.point_count, got.point_count);
            n_fail++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Valid stays high after the accepting edge; the next driver call moves or drops it
  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    shadow_write(idx, d);
  endtask

  // Wait until every result is in, then let the block settle
  task automatic drain();
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (fit_results_due.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic drive_point(logic [11:0] px, logic [11:0] py, bit last);
    cfg_ch.valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.point_x    <= px;
    in_ch.point_y    <= py;
    in_ch.last_point <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_point(logic [11:0] px, logic [11:0] py, bit last);
    fit_result_t res;
    drive_point(px, py, last);
    if (score_point(px, py, last, res)) queue_result(res);
  endtask

  task automatic random_ellipse();
    logic [31:0] w, h;
    w = ($urandom_range(9) == 0) ? $urandom : $urandom_range(256 * 1500, 512);
    h = ($urandom_range(9) == 0) ? $urandom : $urandom_range(256 * 1500, 512);
    if ($urandom_range(19) == 0) w = 0;
    write_reg(REG_CENTER_X, ($urandom_range(4) == 0) ? $urandom :
              32'($urandom_range(256 * 4000)));
    write_reg(REG_CENTER_Y, ($urandom_range(4) == 0) ? $urandom :
              32'($urandom_range(256 * 4000)));
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_ANGLE, ($urandom_range(3) == 0) ? $urandom : $urandom_range(92159));
    write_reg(REG_MAX_ERROR, ($urandom_range(3) == 0) ? $urandom : $urandom_range(200000));
  endtask

  // Contour of points near the configured ellipse, with some noise points
  task automatic random_contour(int npts);
    real ang, a, b, c, s, ux, vy, cxp, cyp;
    int  x, y;
    cxp = real'(m_cx) / 256.0;
    cyp = real'(m_cy) / 256.0;
    a = real'(m_w) / 512.0;
    b = real'(m_h) / 512.0;
    c = real'(m_cos) / 65536.0;
    s = real'(m_sin) / 65536.0;
    for (int k = 0; k < npts; k++) begin
      if ($urandom_range(9) == 0) begin
        x = $urandom_range(4095);
        y = $urandom_range(4095);
      end else begin
        ang = real'($urandom_range(6283)) / 1000.0;
        ux = a * $cos(ang) * (0.9 + real'($urandom_range(200)) / 1000.0);
        vy = b * $sin(ang) * (0.9 + real'($urandom_range(200)) / 1000.0);
        x = int'(cxp + ux * c - vy * s);
        y = int'(cyp + ux * s + vy * c);
        if (x < 0) x = 0;
        if (x > 4095) x = 4095;
        if (y < 0) y = 0;
        if (y > 4095) y = 4095;
      end
      send_point(x[11:0], y[11:0], k == npts - 1);
    end
  endtask

  stim_row_t directed[$];

  task automatic add_row(stim_row_t r);
    directed = {directed, r};
  endtask

  function automatic stim_row_t cfg_row(logic [2:0] idx, logic [31:0] d);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1; r.reg_idx = idx; r.reg_data = d;
    return r;
  endfunction

  function automatic stim_row_t pt_row(logic [11:0] x, logic [11:0] y, bit last);
    stim_row_t r;
    r = '{default: '0};
    r.px = x; r.py = y; r.last = last;
    return r;
  endfunction

  initial begin
    fit_result_t res;
    stim_row_t   r;
    int          phase_items;
    n_fail = 0;
    send_idle_pct = 29;
    recv_idle_pct = 72;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.last_point = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    m_cx = 0; m_cy = 0; m_w = 0; m_h = 0; m_angle = 0; m_max_err = 0;
    m_sum = '0; m_count = 0;
    recompute_trig();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (30) @(posedge clk);

    // Zero axis after reset: points counted, error zero, never ok
    r = pt_row(12'd0, 12'd0, 1'b0);
    add_row(r);
    r = pt_row(12'hFFF, 12'hFFF, 1'b1);
    r.has_exp = 1; r.exp_res = '{1'b0, 40'd0, 13'd2};
    add_row(r);
    // Unit circle at origin, extreme thresholds and angles
    add_row(cfg_row(REG_WIDTH, 32'd512));
    add_row(cfg_row(REG_HEIGHT, 32'd512));
    add_row(cfg_row(REG_MAX_ERROR, 32'hFFFF_FFFF));
    add_row(pt_row(12'd1, 12'd0, 1'b0));
    add_row(pt_row(12'd0, 12'd1, 1'b0));
    add_row(pt_row(12'hFFF, 12'd0, 1'b1));
    add_row(cfg_row(REG_ANGLE, 32'd92159));
    add_row(cfg_row(REG_CENTER_X, 32'h000F_FFFF));
    add_row(cfg_row(REG_CENTER_Y, 32'hFFF0_0000));
    add_row(pt_row(12'hFFF, 12'hFFF, 1'b0));
    add_row(pt_row(12'd0, 12'hFFF, 1'b1));
    // Wrapped angle, maximum width, height of one, zero threshold
    add_row(cfg_row(REG_ANGLE, 32'h0001_FFFF));
    add_row(cfg_row(REG_WIDTH, 32'hFFFF_FFFF));
    add_row(cfg_row(REG_HEIGHT, 32'd1));
    add_row(cfg_row(REG_MAX_ERROR, 32'd0));
    add_row(pt_row(12'd7, 12'd3000, 1'b0));
    add_row(pt_row(12'd2048, 12'd2048, 1'b1));
    add_row(cfg_row(REG_ANGLE, 32'd23040));
    add_row(pt_row(12'd100, 12'd200, 1'b1));

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        drain();
        write_reg(directed[i].reg_idx, directed[i].reg_data);
      end else if (directed[i].has_exp) begin
        // Expected result typed in; still advance the shadow state
        drive_point(directed[i].px, directed[i].py, directed[i].last);
        void'(score_point(directed[i].px, directed[i].py, directed[i].last, res));
        queue_result(directed[i].exp_res);
      end else begin
        send_point(directed[i].px, directed[i].py, directed[i].last);
      end
    end
    drain();

    // Random phases with differing idle patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 72 : 0;
      recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 29 : 0;
      phase_items = 0;
      while (phase_items < 270) begin
        random_ellipse();
        for (int c = 0; c < 3; c++) begin
          int n;
          n = ($urandom_range(7) == 0) ? 1 : $urandom_range(30, 2);
          random_contour(n);
          phase_items += n;
        end
        // Sender holds off until the block has delivered everything
        drain();
      end
    end
    drain();

    if (n_fail == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== ellipse_fit_residual_check.f =====
+incdir+hw/rtl
hw/rtl/ecr_pkg.sv
hw/rtl/ecr_if.sv
hw/rtl/ecr_cordic.sv
hw/rtl/ecr_divsqrt.sv
hw/rtl/ellipse_fit_residual_check.sv
hw/rtl/ecr_checker.sv
tb/tb_ellipse_fit_residual_check.sv
